/* hw/rtl/color_mask_centroid_tracker_top_defines.svh */
// Assertion macros shared by the color mask centroid tracker RTL.
`ifndef COLOR_MASK_CENTROID_TRACKER_TOP_DEFINES_SVH
`define COLOR_MASK_CENTROID_TRACKER_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define CMCT_ASSERT_SAME(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("cmct check failed");

// Condition holds in the cycle after the trigger.
`define CMCT_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("cmct check failed");

`endif

/* hw/rtl/cmct_pkg.sv */
// Shared constants and types of the color mask centroid tracker.
package cmct_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Field and accumulator widths.
    localparam int CHAN_W    = 8;
    localparam int IMG_W_W   = 12;
    localparam int COORD_W   = 11;
    localparam int TOTAL_W   = 23;
    localparam int SUM_W     = 33;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int M_DATA_W  = 72;

    // A mask stops counting once its total reaches this value.
    localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(MAX_WIDTH * MAX_HEIGHT);

    // Register reset values.
    localparam logic [IMG_W_W-1:0] IMG_WIDTH_RESET = 12'd640;
    localparam logic [CHAN_W-1:0]  BLUE_THR_RESET  = 8'd200;
    localparam logic [CHAN_W-1:0]  GREEN_THR_RESET = 8'd180;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_BLUE_BLUE_MIN = 3'd1,
        CFG_BLUE_GREEN_LIM = 3'd2,
        CFG_BLUE_RED_LIM  = 3'd3,
        CFG_GREEN_BLUE_LIM = 3'd4,
        CFG_GREEN_GREEN_MIN = 3'd5,
        CFG_GREEN_RED_LIM = 3'd6
    } cmct_cfg_index_t;

    // Accumulated statistics of one frame.
    typedef struct packed {
        logic [TOTAL_W-1:0] blue_total;
        logic [SUM_W-1:0]   blue_col_sum;
        logic [SUM_W-1:0]   blue_row_sum;
        logic [TOTAL_W-1:0] green_total;
        logic [SUM_W-1:0]   green_col_sum;
        logic [SUM_W-1:0]   green_row_sum;
    } cmct_frame_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } cmct_queue_status_t;

    // Control shared by the four dividers.
    typedef struct packed {
        logic              load;
        logic              step;
        logic [STEP_W-1:0] shift;
    } cmct_div_ctrl_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_HOLD
    } cmct_back_state_t;

endpackage

/* hw/rtl/cmct_front.sv */
// Front end: pixel intake, mask classification and per-frame accumulation.
module cmct_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmct_pkg::IMG_W_W-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    input  logic                              s_tlast,
    input  cmct_pkg::cmct_queue_status_t      q_status,
    output logic                              push,
    output cmct_pkg::cmct_frame_t             push_data
);
    import cmct_pkg::*;

    logic [IMG_W_W-1:0] img_width_reg;
    logic [CHAN_W-1:0]  b_blue_min_reg;
    logic [CHAN_W-1:0]  b_green_lim_reg;
    logic [CHAN_W-1:0]  b_red_lim_reg;
    logic [CHAN_W-1:0]  g_blue_lim_reg;
    logic [CHAN_W-1:0]  g_green_min_reg;
    logic [CHAN_W-1:0]  g_red_lim_reg;

    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    cmct_frame_t        acc_reg;
    cmct_frame_t        acc_next;

    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic               accept;
    logic               blue_hit;
    logic               green_hit;
    logic [IMG_W_W-1:0] eff_width;
    logic               col_wrap;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg   <= IMG_WIDTH_RESET;
            b_blue_min_reg  <= BLUE_THR_RESET;
            b_green_lim_reg <= BLUE_THR_RESET;
            b_red_lim_reg   <= BLUE_THR_RESET;
            g_blue_lim_reg  <= GREEN_THR_RESET;
            g_green_min_reg <= GREEN_THR_RESET;
            g_red_lim_reg   <= GREEN_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:     img_width_reg   <= cfg_data;
                CFG_BLUE_BLUE_MIN:   b_blue_min_reg  <= cfg_data[CHAN_W-1:0];
                CFG_BLUE_GREEN_LIM:  b_green_lim_reg <= cfg_data[CHAN_W-1:0];
                CFG_BLUE_RED_LIM:    b_red_lim_reg   <= cfg_data[CHAN_W-1:0];
                CFG_GREEN_BLUE_LIM:  g_blue_lim_reg  <= cfg_data[CHAN_W-1:0];
                CFG_GREEN_GREEN_MIN: g_green_min_reg <= cfg_data[CHAN_W-1:0];
                CFG_GREEN_RED_LIM:   g_red_lim_reg   <= cfg_data[CHAN_W-1:0];
                default:             ;
            endcase
        end
    end

    // A pixel is taken whenever the queue has room for a frame record.
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    assign blue  = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign red   = s_tdata[23:16];

    // Mask tests; a mask that has reached its cap takes no more pixels.
    assign blue_hit  = (blue >= b_blue_min_reg) && (green < b_green_lim_reg) &&
                       (red < b_red_lim_reg) && (acc_reg.blue_total < TOTAL_CAP);
    assign green_hit = (blue < g_blue_lim_reg) && (green >= g_green_min_reg) &&
                       (red < g_red_lim_reg) && (acc_reg.green_total < TOTAL_CAP);

    // Accumulators including the current pixel.
    always_comb
    begin
        acc_next = acc_reg;
        if (blue_hit)
        begin
            acc_next.blue_total   = acc_reg.blue_total + 1'b1;
            acc_next.blue_col_sum = acc_reg.blue_col_sum + SUM_W'(col_reg);
            acc_next.blue_row_sum = acc_reg.blue_row_sum + SUM_W'(row_reg);
        end
        if (green_hit)
        begin
            acc_next.green_total   = acc_reg.green_total + 1'b1;
            acc_next.green_col_sum = acc_reg.green_col_sum + SUM_W'(col_reg);
            acc_next.green_row_sum = acc_reg.green_row_sum + SUM_W'(row_reg);
        end
    end

    // Zero or oversized widths mean the full line.
    assign eff_width = ((img_width_reg == '0) || (img_width_reg > IMG_W_W'(MAX_WIDTH))) ?
                       IMG_W_W'(MAX_WIDTH) : img_width_reg;
    assign col_wrap  = (IMG_W_W'(col_reg) + IMG_W_W'(1)) >= eff_width;

    // The last pixel hands the finished frame to the queue.
    assign push      = accept && s_tlast;
    assign push_data = acc_next;

    // Position counters and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                col_reg <= '0;
                row_reg <= '0;
                acc_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
                if (col_wrap)
                begin
                    col_reg <= '0;
                    if (row_reg < COORD_W'(MAX_HEIGHT - 1))
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/cmct_queue.sv */
// Two-entry queue of finished frame records between front and back end.
module cmct_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  cmct_pkg::cmct_frame_t        push_data,
    input  logic                         pop,
    output cmct_pkg::cmct_frame_t        pop_data,
    output cmct_pkg::cmct_queue_status_t status
);
    import cmct_pkg::*;

    cmct_frame_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/cmct_div.sv */
// Shift-subtract divider producing one quotient bit per step, high bit first.
module cmct_div (
    input  logic                          clk,
    input  cmct_pkg::cmct_div_ctrl_t      ctrl,
    input  logic [cmct_pkg::SUM_W-1:0]    dividend,
    input  logic [cmct_pkg::TOTAL_W-1:0]  divisor,
    output logic [cmct_pkg::COORD_W-1:0]  quotient
);
    import cmct_pkg::*;

    logic [SUM_W-1:0]   rem_reg;
    logic [TOTAL_W-1:0] div_reg;
    logic [COORD_W-1:0] quot_reg;
    logic [SUM_W:0]     trial;
    logic               fits;

    // The mean never exceeds the largest coordinate, so COORD_W steps suffice.
    assign trial    = (SUM_W + 1)'(div_reg) << ctrl.shift;
    assign fits     = {1'b0, rem_reg} >= trial;
    assign quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg  <= dividend;
            div_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (ctrl.step && fits)
        begin
            rem_reg            <= rem_reg - trial[SUM_W-1:0];
            quot_reg[ctrl.shift] <= 1'b1;
        end
    end

endmodule

/* hw/rtl/cmct_back.sv */
// Back end: takes frame records, divides out the centroids, holds the result.
module cmct_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cmct_pkg::cmct_queue_status_t      q_status,
    input  cmct_pkg::cmct_frame_t             pop_data,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cmct_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tuser
);
    import cmct_pkg::*;

    cmct_back_state_t   state_reg;
    cmct_back_state_t   state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               detect_reg;
    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic               out_user_reg;

    cmct_div_ctrl_t     div_ctrl;
    logic               both_present;
    logic               out_free;
    logic               out_load;
    logic [COORD_W-1:0] blue_x;
    logic [COORD_W-1:0] blue_y;
    logic [COORD_W-1:0] green_x;
    logic [COORD_W-1:0] green_y;
    logic [COORD_W:0]   mid_x_sum;
    logic [COORD_W:0]   mid_y_sum;

    assign both_present = (pop_data.blue_total != '0) && (pop_data.green_total != '0);
    assign out_free     = !out_valid_reg || m_tready;

    // Four dividers share one step sequence.
    cmct_div u_div_bx (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (pop_data.blue_col_sum),
        .divisor  (pop_data.blue_total),
        .quotient (blue_x)
    );

    cmct_div u_div_by (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (pop_data.blue_row_sum),
        .divisor  (pop_data.blue_total),
        .quotient (blue_y)
    );

    cmct_div u_div_gx (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (pop_data.green_col_sum),
        .divisor  (pop_data.green_total),
        .quotient (green_x)
    );

    cmct_div u_div_gy (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (pop_data.green_row_sum),
        .divisor  (pop_data.green_total),
        .quotient (green_y)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BACK_IDLE;
            step_reg   <= '0;
            detect_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (pop)
            begin
                detect_reg <= both_present;
            end
        end
    end

    // Sequencer: load, run the quotient bits when both masks hold pixels, then wait for the output slot.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        div_ctrl.load  = 1'b0;
        div_ctrl.step  = 1'b0;
        div_ctrl.shift = step_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop           = 1'b1;
                    div_ctrl.load = 1'b1;
                    step_next     = STEP_W'(COORD_W - 1);
                    state_next    = both_present ? BACK_DIVIDE : BACK_HOLD;
                end
            end
            BACK_DIVIDE:
            begin
                div_ctrl.step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = BACK_HOLD;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            BACK_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // Midpoints of the two centroids; empty frames leave all quotients at zero.
    assign mid_x_sum = (COORD_W + 1)'(blue_x) + (COORD_W + 1)'(green_x);
    assign mid_y_sum = (COORD_W + 1)'(blue_y) + (COORD_W + 1)'(green_y);

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {6'd0, green_y, green_x, blue_y, blue_x,
                             mid_y_sum[COORD_W:1], mid_x_sum[COORD_W:1]};
            out_user_reg <= detect_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* hw/rtl/color_mask_centroid_tracker_top.sv */
// Top level of the color mask centroid tracker.
//
// Pixels enter on the s_ stream in raster order, one request per pixel with
// blue, green and red bytes in s_tdata and s_tlast on the last pixel of a
// frame. The block takes one pixel per clock for as long as its frame queue
// has room; the queue holds two finished frames.
// Each frame yields one result request on the m_ stream: m_tuser is the
// detected flag and m_tdata holds the midpoint and the two mask centroids.
// With both masks present a result passes the queue, eleven divider steps
// and the output load; with a mask empty the divider steps are skipped. The
// back end pops the next frame record only after loading the last result.
// When the receiver stalls, the result waits in the output register, the
// back end holds its next result, and once the queue fills s_tready drops.
// Configuration is written through cfg_we, cfg_index and cfg_data while
// the block is idle; the user must keep to that, the block does not enforce
// it. Reset clears the counters, the accumulators, the queue and the output
// valid, and restores the default thresholds and width.
`include "color_mask_centroid_tracker_top_defines.svh"

module color_mask_centroid_tracker_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cmct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cmct_pkg::IMG_W_W-1:0]       cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata from bit 0: pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16]
    input  logic [23:0]                        s_tdata,
    // s_tlast: frame_end
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata from bit 0: center_x, center_y, blue_x, blue_y, green_x,
    // green_y (11 bits each), then zero padding up to 72 bits
    output logic [cmct_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: detected
    output logic                               m_tuser
);
    import cmct_pkg::*;

    cmct_queue_status_t q_status;
    cmct_frame_t        push_data;
    cmct_frame_t        pop_data;
    logic               push;
    logic               pop;
    logic [COORD_W:0]   chk_mid_x;

    cmct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    cmct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    cmct_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Midpoint of the delivered column centroids, for checking.
    assign chk_mid_x = (COORD_W + 1)'(m_tdata[32:22]) + (COORD_W + 1)'(m_tdata[54:44]);

    // A taken frame end always leaves a record waiting in the queue.
    `CMCT_ASSERT_NEXT(a_frame_queued, s_tvalid && s_tready && s_tlast, !q_status.empty)

    // A result without detection carries only zero coordinates.
    `CMCT_ASSERT_SAME(a_empty_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // The reported column midpoint agrees with the two column centroids.
    `CMCT_ASSERT_SAME(a_mid_x, m_tvalid && m_tuser, m_tdata[10:0] == chk_mid_x[COORD_W:1])

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the color mask centroid tracker top level.
`timescale 1ns / 1ps

module tb;
    import cmct_pkg::*;

    // Run limits and timing.
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned DRAIN_CYCLES    = 24;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned RANDOM_PHASES   = 10;
    localparam int unsigned PHASE_PIXELS    = 95;
    localparam int unsigned LONG_FRAME      = 120;
    localparam int unsigned REPORT_LINES    = 40;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum {PIX_BLUE, PIX_GREEN, PIX_NOISE} pixel_kind_t;
    typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} ready_mode_t;

    typedef struct {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              frame_end;
    } pixel_t;

    typedef struct {
        logic               detected;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] blue_x;
        logic [COORD_W-1:0] blue_y;
        logic [COORD_W-1:0] green_x;
        logic [COORD_W-1:0] green_y;
    } centroid_t;

    // Block ports.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [IMG_W_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;

    // Shadow of the configuration registers.
    logic [IMG_W_W-1:0] img_width      = IMG_WIDTH_RESET;
    logic [CHAN_W-1:0]  blue_min       = BLUE_THR_RESET;
    logic [CHAN_W-1:0]  blue_green_lim = BLUE_THR_RESET;
    logic [CHAN_W-1:0]  blue_red_lim   = BLUE_THR_RESET;
    logic [CHAN_W-1:0]  green_blue_lim = GREEN_THR_RESET;
    logic [CHAN_W-1:0]  green_min      = GREEN_THR_RESET;
    logic [CHAN_W-1:0]  green_red_lim  = GREEN_THR_RESET;

    // Predicted frame statistics.
    logic [COORD_W-1:0] col_pos       = '0;
    logic [COORD_W-1:0] row_pos       = '0;
    logic [TOTAL_W-1:0] blue_total    = '0;
    logic [SUM_W-1:0]   blue_col_sum  = '0;
    logic [SUM_W-1:0]   blue_row_sum  = '0;
    logic [TOTAL_W-1:0] green_total   = '0;
    logic [SUM_W-1:0]   green_col_sum = '0;
    logic [SUM_W-1:0]   green_row_sum = '0;

    centroid_t pending_centroids[$];

    // Sender and receiver pacing.
    int unsigned burst_left    = 0;
    bit          sender_steady = 1'b0;
    bit          hold_off_req  = 1'b0;
    int unsigned hold_off_left = 0;
    int unsigned ready_left    = 0;
    ready_mode_t ready_mode    = READY_ALWAYS;

    // Statistics.
    int unsigned error_count        = 0;
    int unsigned cycle_count        = 0;
    int unsigned pixels_sent        = 0;
    int unsigned frames_checked     = 0;
    int unsigned frames_detected    = 0;
    int unsigned settings_applied   = 0;
    int unsigned input_stall_cycles = 0;

    color_mask_centroid_tracker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_centroids.size());
            $display("** color_mask_centroid_tracker_top: FAILED **");
            $finish;
        end
    end

    // Advance the frame statistics by one accepted pixel and queue the
    // expected result when the pixel closes the frame.
    function automatic void track_pixel(input pixel_t px);
        centroid_t        res;
        logic [SUM_W-1:0] bx, by, gx, gy;
        int unsigned      span;
        span = (img_width == 0 || img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
        if (px.blue >= blue_min && px.green < blue_green_lim && px.red < blue_red_lim
            && blue_total < TOTAL_CAP)
        begin
            blue_total   = blue_total + 1'b1;
            blue_col_sum = blue_col_sum + col_pos;
            blue_row_sum = blue_row_sum + row_pos;
        end
        if (px.blue < green_blue_lim && px.green >= green_min && px.red < green_red_lim
            && green_total < TOTAL_CAP)
        begin
            green_total   = green_total + 1'b1;
            green_col_sum = green_col_sum + col_pos;
            green_row_sum = green_row_sum + row_pos;
        end
        if (!px.frame_end)
        begin
            // Raster position; the row stops at the last row the block can count.
            if (col_pos + 1 >= span)
            begin
                col_pos = '0;
                if (row_pos < MAX_HEIGHT - 1)
                    row_pos = row_pos + 1'b1;
            end
            else
                col_pos = col_pos + 1'b1;
            return;
        end
        res = '{default: '0};
        if (blue_total != 0 && green_total != 0)
        begin
            bx = blue_col_sum / blue_total;
            by = blue_row_sum / blue_total;
            gx = green_col_sum / green_total;
            gy = green_row_sum / green_total;
            res.detected = 1'b1;
            res.center_x = COORD_W'((bx + gx) >> 1);
            res.center_y = COORD_W'((by + gy) >> 1);
            res.blue_x   = COORD_W'(bx);
            res.blue_y   = COORD_W'(by);
            res.green_x  = COORD_W'(gx);
            res.green_y  = COORD_W'(gy);
        end
        pending_centroids.insert(pending_centroids.size(), res);
        col_pos       = '0;
        row_pos       = '0;
        blue_total    = '0;
        blue_col_sum  = '0;
        blue_row_sum  = '0;
        green_total   = '0;
        green_col_sum = '0;
        green_row_sum = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < REPORT_LINES)
            $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compare one accepted result request with the oldest expectation.
    task automatic check_centroid();
        centroid_t want;
        if (pending_centroids.size() == 0)
        begin
            report_mismatch("result with nothing expected", m_tdata[63:0], '0);
            return;
        end
        want = pending_centroids.pop_front();
        frames_checked++;
        if (want.detected)
            frames_detected++;
        check_field("detected", m_tuser, want.detected);
        check_field("center_x", m_tdata[0*COORD_W +: COORD_W], want.center_x);
        check_field("center_y", m_tdata[1*COORD_W +: COORD_W], want.center_y);
        check_field("blue_x", m_tdata[2*COORD_W +: COORD_W], want.blue_x);
        check_field("blue_y", m_tdata[3*COORD_W +: COORD_W], want.blue_y);
        check_field("green_x", m_tdata[4*COORD_W +: COORD_W], want.green_x);
        check_field("green_y", m_tdata[5*COORD_W +: COORD_W], want.green_y);
        check_field("padding", m_tdata[M_DATA_W-1:6*COORD_W], '0);
    endtask

    // Results are taken at the edge where valid and ready were both high.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
            if (m_tvalid && m_tready)
                check_centroid();
        end
    end

    // Receiver: picks a new random stall pattern whenever the current one runs out, and
    // holds off completely for a long stretch when asked.
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (ready_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                ready_left = $urandom_range(20, 300);
            end
            ready_left--;
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= ((ready_left % 8) < 5);
            endcase
        end
    end

    // Offer one pixel request and wait until it is taken. Bursts of random
    // length are separated by random gaps unless the sender runs steady.
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {px.red, px.green, px.blue};
        s_tlast  <= px.frame_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_pixel(px);
        pixels_sent++;
    endtask

    function automatic pixel_t make_pixel(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r, input logic last);
        pixel_t px;
        px.blue      = b;
        px.green     = g;
        px.red       = r;
        px.frame_end = last;
        return px;
    endfunction

    function automatic logic [7:0] at_least(input logic [7:0] floor_v);
        return 8'($urandom_range(255, floor_v));
    endfunction

    // A byte below the limit; with a zero limit no byte qualifies.
    function automatic logic [7:0] below(input logic [7:0] ceil_v);
        return (ceil_v == 0) ? 8'($urandom) : 8'($urandom_range(ceil_v - 1, 0));
    endfunction

    // Mostly pixels aimed at one of the masks under the current thresholds,
    // the rest plain noise.
    function automatic pixel_t random_pixel(input logic last);
        pixel_t      px;
        pixel_kind_t kind;
        kind = pixel_kind_t'($urandom_range(0, 2));
        px.frame_end = last;
        case (kind)
            PIX_BLUE:
            begin
                px.blue  = at_least(blue_min);
                px.green = below(blue_green_lim);
                px.red   = below(blue_red_lim);
            end
            PIX_GREEN:
            begin
                px.blue  = below(green_blue_lim);
                px.green = at_least(green_min);
                px.red   = below(green_red_lim);
            end
            default:
            begin
                px.blue  = 8'($urandom);
                px.green = 8'($urandom);
                px.red   = 8'($urandom);
            end
        endcase
        return px;
    endfunction

    task automatic send_frame(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_pixel(random_pixel(i == len - 1));
    endtask

    // Stop offering and wait for every expected result, then for the back
    // end to settle.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_centroids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [IMG_W_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:     img_width      = value;
            CFG_BLUE_BLUE_MIN:   blue_min       = value[7:0];
            CFG_BLUE_GREEN_LIM:  blue_green_lim = value[7:0];
            CFG_BLUE_RED_LIM:    blue_red_lim   = value[7:0];
            CFG_GREEN_BLUE_LIM:  green_blue_lim = value[7:0];
            CFG_GREEN_GREEN_MIN: green_min      = value[7:0];
            CFG_GREEN_RED_LIM:   green_red_lim  = value[7:0];
            default: ;
        endcase
    endtask

    // Write every register once the block is idle. Byte registers get junk
    // in the unused upper bits, which the block must drop.
    task automatic apply_settings(input logic [IMG_W_W-1:0] w,
                                  input logic [7:0] bb, input logic [7:0] bg,
                                  input logic [7:0] br, input logic [7:0] gb,
                                  input logic [7:0] gg, input logic [7:0] gr);
        wait_until_drained();
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_BLUE_BLUE_MIN, {4'($urandom), bb});
        write_register(CFG_BLUE_GREEN_LIM, {4'($urandom), bg});
        write_register(CFG_BLUE_RED_LIM, {4'($urandom), br});
        write_register(CFG_GREEN_BLUE_LIM, {4'($urandom), gb});
        write_register(CFG_GREEN_GREEN_MIN, {4'($urandom), gg});
        write_register(CFG_GREEN_RED_LIM, {4'($urandom), gr});
        write_register(CFG_UNUSED_INDEX, 12'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Reset thresholds: channel extremes, mask boundaries, a frame with one
    // mask empty, and a frame whose closing pixel is the only blue one.
    task automatic test_directed_pixels();
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd200, 8'd199, 8'd199, 1'b0));
        send_pixel(make_pixel(8'd179, 8'd180, 8'd179, 1'b0));
        send_pixel(make_pixel(8'd199, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd179, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
        // Frame with nothing masked.
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
        // Green mask empty.
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
        // Blue mask empty.
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b1));
        // The closing pixel counts at its own column.
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b1));
    endtask

    // A zero width and one above the maximum both mean the maximum width,
    // so a frame shorter than that line stays on the first row.
    task automatic test_width_limits();
        apply_settings(12'd0, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
        send_frame(LONG_FRAME);
        apply_settings(12'd4095, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
        send_frame(LONG_FRAME);
    endtask

    // One pixel per row moves the row counter on every pixel.
    task automatic test_single_column();
        apply_settings(12'd1, 8'd100, 8'd150, 8'd150, 8'd100, 8'd150, 8'd150);
        send_frame(LONG_FRAME);
    endtask

    // The receiver holds off while the sender streams short frames, so the
    // frame queue fills and the input stalls; then the sender waits.
    task automatic test_backpressure();
        apply_settings(12'd4, 8'd150, 8'd120, 8'd120, 8'd120, 8'd150, 8'd120);
        hold_off_req  = 1'b1;
        sender_steady = 1'b1;
        repeat (30) send_frame($urandom_range(1, 3));
        sender_steady = 1'b0;
        wait_until_drained();
    endtask

    // Random frames over a series of settings, the extremes first.
    task automatic test_random_frames();
        int unsigned goal;
        logic [IMG_W_W-1:0] w;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            w = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(1, 24));
            case (phase)
                0: apply_settings(12'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                1: apply_settings(12'd2048, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                // Loose limits let one pixel fall into both masks.
                2: apply_settings(12'd3, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
                3: apply_settings(12'd2, 8'd255, 8'd1, 8'd1, 8'd1, 8'd255, 8'd1);
                default: apply_settings(w, 8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            goal = pixels_sent + PHASE_PIXELS;
            while (pixels_sent < goal)
                send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                                       : $urandom_range(1, 12));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_pixels();
        test_width_limits();
        test_single_column();
        test_backpressure();
        test_random_frames();
        wait_until_drained();
        $display("Checked %0d frame results (%0d with both masks) from %0d pixels",
                 frames_checked, frames_detected, pixels_sent);
        $display("over %0d register settings; input held back for %0d cycles.",
                 settings_applied, input_stall_cycles);
        if (error_count == 0)
            $display("** color_mask_centroid_tracker_top: PASSED **");
        else
            $display("** color_mask_centroid_tracker_top: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cmct_pkg.sv
hw/rtl/cmct_front.sv
hw/rtl/cmct_queue.sv
hw/rtl/cmct_div.sv
hw/rtl/cmct_back.sv
hw/rtl/color_mask_centroid_tracker_top.sv
tb/sv/tb.sv
